[hw/rtl/acss_pkg.sv]
// acss_pkg: shared types, codes and constants for the ARIMA CSS residual accumulator.
// Used by acss_mac and arima_css_residual_accumulator_top; depends on nothing.

package acss_pkg;

  // default sizes, overridable on the top level
  localparam int AR_TAPS_MAX_DEF    = 8;
  localparam int MA_TAPS_MAX_DEF    = 8;
  localparam int DIFF_ORDER_MAX_DEF = 2;

  // field widths fixed by the item format
  localparam int SAMPLE_W = 32;
  localparam int COEF_W   = 32;
  localparam int RES_W    = 48;
  localparam int CSS_W    = 63;
  localparam int STEP_W   = 32;

  // shared multiply-accumulate datapath
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 96;
  localparam int CHUNK_W = 24;
  localparam int FRAC_W  = 16;

  localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
  localparam logic [CSS_W-1:0] CSS_MAX = {CSS_W{1'b1}};

  // operation codes
  localparam logic [1:0] OP_LOAD_AR = 2'd0;
  localparam logic [1:0] OP_LOAD_MA = 2'd1;
  localparam logic [1:0] OP_SAMPLE  = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_AR_ORDER   = 2'd0;
  localparam logic [1:0] CFG_MA_ORDER   = 2'd1;
  localparam logic [1:0] CFG_DIFF_ORDER = 2'd2;
  localparam logic [1:0] CFG_INTERCEPT  = 2'd3;

  // product alignment codes
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_24 = 2'd1;
  localparam logic [1:0] SH_25 = 2'd2;
  localparam logic [1:0] SH_48 = 2'd3;

  typedef struct packed {
    logic [1:0]               operation;
    logic [2:0]               coef_slot;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic                     ready_res;
    logic signed [RES_W-1:0]  residual;
    logic [CSS_W-1:0]         css_sum;
    logic                     css_overflow;
    logic [STEP_W-1:0]        steps_done;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       mac;
    logic       sub;
    logic [1:0] shift;
  } mac_ctrl_t;

endpackage

[hw/rtl/arima_css_residual_accumulator_top.sv]
// A sample steps through the states AR (p AR taps in use), MA (m MA terms in use) and RES,
// then SQ and CSS when the square is summed, then OUT; items are accepted only in idle.
// The single shared multiplier makes two passes per tap and three per square.
// Warm-up samples go straight to OUT; loads and restart are taken with no result.
// Reset is asynchronous, active low, and clears all state at once; no clearing pass.
// Top level: sequencer, coefficient/history registers; uses acss_pkg and acss_mac.

module arima_css_residual_accumulator_top #(
  parameter int AR_TAPS_MAX    = acss_pkg::AR_TAPS_MAX_DEF,
  parameter int MA_TAPS_MAX    = acss_pkg::MA_TAPS_MAX_DEF,
  parameter int DIFF_ORDER_MAX = acss_pkg::DIFF_ORDER_MAX_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  acss_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output acss_pkg::out_item_t out_data_o
);

  localparam int TAPS_MAX = (AR_TAPS_MAX > MA_TAPS_MAX) ? AR_TAPS_MAX : MA_TAPS_MAX;
  localparam int TAP_W    = $clog2(TAPS_MAX + 1);
  localparam int D_W      = $clog2(DIFF_ORDER_MAX + 1);
  localparam int FILL_W   = $clog2(DIFF_ORDER_MAX + 2);
  localparam int DW       = acss_pkg::SAMPLE_W + DIFF_ORDER_MAX;
  localparam int RES_W    = acss_pkg::RES_W;
  localparam int ACC_W    = acss_pkg::ACC_W;
  localparam int CHUNK_W  = acss_pkg::CHUNK_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_AR   = 3'd1;
  localparam logic [2:0] ST_MA   = 3'd2;
  localparam logic [2:0] ST_RES  = 3'd3;
  localparam logic [2:0] ST_SQ   = 3'd4;
  localparam logic [2:0] ST_CSS  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  localparam logic [1:0] SQ_LAST = 2'd2;

  logic [2:0] state_q;

  logic [3:0]               ar_order_q;
  logic [3:0]               ma_order_q;
  logic [1:0]               diff_order_q;
  logic signed [31:0]       intercept_q;

  logic signed [acss_pkg::COEF_W-1:0]   ar_coef_q [AR_TAPS_MAX];
  logic signed [acss_pkg::COEF_W-1:0]   ma_coef_q [MA_TAPS_MAX];
  logic signed [acss_pkg::SAMPLE_W-1:0] win_q [DIFF_ORDER_MAX+1];
  logic [FILL_W-1:0]                    fill_q;
  logic signed [DW-1:0]                 diff_hist_q [AR_TAPS_MAX];
  logic signed [RES_W-1:0]              res_hist_q [MA_TAPS_MAX];
  logic [acss_pkg::STEP_W-1:0]          step_q;
  logic [acss_pkg::CSS_W-1:0]           css_q;
  logic                                 ovf_q;

  logic [TAP_W-1:0]        tap_q;
  logic                    half_q;
  logic [1:0]              sq_step_q;
  logic [TAP_W-1:0]        nma_q;
  logic                    sq_en_q;
  logic signed [DW-1:0]    diffv_q;
  logic signed [RES_W-1:0] res_q;
  logic                    rdy_q;
  logic                    out_valid_q;
  acss_pkg::out_item_t     out_q;

  logic                    in_fire;
  logic [TAP_W-1:0]        p_c;
  logic [TAP_W-1:0]        q_c;
  logic [TAP_W-1:0]        ncond_c;
  logic [TAP_W-1:0]        nma_c;
  logic [D_W-1:0]          d_c;
  logic [acss_pkg::STEP_W-1:0] span_c;

  logic signed [acss_pkg::SAMPLE_W-1:0] win_n [DIFF_ORDER_MAX+1];
  logic signed [DW-1:0]    work [DIFF_ORDER_MAX+1];
  logic [FILL_W-1:0]       fill_n;
  logic [FILL_W-1:0]       d1_c;
  logic                    ready_n;
  logic signed [DW-1:0]    diffv_n;
  logic signed [ACC_W-1:0] init_v;

  acss_pkg::mac_ctrl_t                mac_ctrl;
  logic signed [ACC_W-1:0]            mac_load;
  logic signed [acss_pkg::MUL_A_W-1:0] mac_a;
  logic signed [acss_pkg::MUL_B_W-1:0] mac_b;
  logic signed [ACC_W-1:0]            acc;

  logic signed [acss_pkg::COEF_W-1:0] ar_sel;
  logic signed [acss_pkg::COEF_W-1:0] ma_sel;
  logic signed [RES_W-1:0]            dh_sel;
  logic signed [RES_W-1:0]            rh_sel;
  logic signed [RES_W-1:0]            b_src;
  logic signed [RES_W-1:0]            resid_c;
  logic [acss_pkg::CSS_W+17:0]        css_sum_c;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // effective orders, clamped to the hardware maxima
  always_comb begin
    p_c = (32'(ar_order_q) > AR_TAPS_MAX) ? TAP_W'(AR_TAPS_MAX) : TAP_W'(ar_order_q);
    q_c = (32'(ma_order_q) > MA_TAPS_MAX) ? TAP_W'(MA_TAPS_MAX) : TAP_W'(ma_order_q);
    d_c = (32'(diff_order_q) > DIFF_ORDER_MAX) ? D_W'(DIFF_ORDER_MAX) : D_W'(diff_order_q);
    ncond_c = (p_c > q_c) ? p_c : q_c;
    span_c  = '0;
    nma_c   = '0;
    if (step_q > 32'(ncond_c)) begin
      span_c = step_q - 32'(ncond_c);
      nma_c  = (span_c < 32'(q_c)) ? TAP_W'(span_c) : q_c;
    end
  end

  // raw window update and d-th forward difference of the new sample
  always_comb begin
    for (int i = 0; i <= DIFF_ORDER_MAX; i++) begin
      win_n[i] = win_q[i];
    end
    fill_n  = fill_q;
    ready_n = 1'b1;
    d1_c    = FILL_W'(d_c) + FILL_W'(1);
    if (d_c != '0) begin
      if (fill_q < d1_c) begin
        for (int i = 0; i <= DIFF_ORDER_MAX; i++) begin
          if (FILL_W'(i) == fill_q) win_n[i] = in_data_i.sample;
        end
        fill_n  = fill_q + FILL_W'(1);
        ready_n = (fill_q + FILL_W'(1)) >= d1_c;
      end else begin
        for (int i = 0; i < DIFF_ORDER_MAX; i++) begin
          if (i < int'(d_c)) win_n[i] = win_q[i+1];
        end
        for (int i = 0; i <= DIFF_ORDER_MAX; i++) begin
          if (i == int'(d_c)) win_n[i] = in_data_i.sample;
        end
      end
    end
    for (int i = 0; i <= DIFF_ORDER_MAX; i++) begin
      work[i] = DW'(win_n[i]);
    end
    for (int i = 0; i < DIFF_ORDER_MAX; i++) begin
      for (int j = 0; j < DIFF_ORDER_MAX; j++) begin
        if (i < int'(d_c) && j < int'(d_c) - i) work[j] = work[j+1] - work[j];
      end
    end
    diffv_n = (d_c == '0) ? DW'(in_data_i.sample) : work[0];
    // (diff - intercept) in Q.32 plus the rounding half
    init_v = ((ACC_W'(diffv_n) - ACC_W'(intercept_q)) <<< acss_pkg::FRAC_W)
             + (ACC_W'(1) <<< (acss_pkg::FRAC_W - 1));
  end

  // tap operand selection
  always_comb begin
    ar_sel = '0;
    dh_sel = '0;
    for (int i = 0; i < AR_TAPS_MAX; i++) begin
      if (TAP_W'(i) == tap_q) begin
        ar_sel = ar_coef_q[i];
        dh_sel = RES_W'(diff_hist_q[i]);
      end
    end
    ma_sel = '0;
    rh_sel = '0;
    for (int i = 0; i < MA_TAPS_MAX; i++) begin
      if (TAP_W'(i) == tap_q) begin
        ma_sel = ma_coef_q[i];
        rh_sel = res_hist_q[i];
      end
    end
  end

  // sequencer drive of the shared multiply-accumulate
  always_comb begin
    mac_ctrl = '0;
    mac_load = init_v;
    mac_a    = '0;
    mac_b    = '0;
    b_src    = dh_sel;
    unique case (state_q) inside
      ST_IDLE: begin
        mac_ctrl.load = in_fire && (in_data_i.operation == acss_pkg::OP_SAMPLE) && ready_n;
      end
      ST_AR, ST_MA: begin
        if (state_q == ST_AR) begin
          mac_a        = acss_pkg::MUL_A_W'(ar_sel);
          b_src        = dh_sel;
          mac_ctrl.mac = (tap_q != p_c);
        end else begin
          mac_a        = acss_pkg::MUL_A_W'(ma_sel);
          b_src        = rh_sel;
          mac_ctrl.mac = (tap_q != nma_q);
        end
        mac_ctrl.sub = 1'b1;
        if (half_q) begin
          mac_b          = {b_src[RES_W-1], b_src[RES_W-1:CHUNK_W]};
          mac_ctrl.shift = acss_pkg::SH_24;
        end else begin
          mac_b          = {1'b0, b_src[CHUNK_W-1:0]};
          mac_ctrl.shift = acss_pkg::SH_0;
        end
      end
      ST_RES: begin
        mac_ctrl.load = 1'b1;
        mac_load      = ACC_W'(1) <<< (acss_pkg::FRAC_W - 1);
      end
      ST_SQ: begin
        // r^2 = rl*rl + 2*rh*rl*2^24 + rh*rh*2^48, rh signed, rl unsigned
        mac_ctrl.mac = 1'b1;
        case (sq_step_q)
          2'd0: begin
            mac_a          = {{(acss_pkg::MUL_A_W-CHUNK_W){1'b0}}, res_q[CHUNK_W-1:0]};
            mac_b          = {1'b0, res_q[CHUNK_W-1:0]};
            mac_ctrl.shift = acss_pkg::SH_0;
          end
          2'd1: begin
            mac_a          = acss_pkg::MUL_A_W'($signed(res_q[RES_W-1:CHUNK_W]));
            mac_b          = {1'b0, res_q[CHUNK_W-1:0]};
            mac_ctrl.shift = acss_pkg::SH_25;
          end
          default: begin
            mac_a          = acss_pkg::MUL_A_W'($signed(res_q[RES_W-1:CHUNK_W]));
            mac_b          = {res_q[RES_W-1], res_q[RES_W-1:CHUNK_W]};
            mac_ctrl.shift = acss_pkg::SH_48;
          end
        endcase
      end
      default: begin
        mac_ctrl = '0;
      end
    endcase
  end

  acss_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mac_ctrl),
    .load_val_i (mac_load),
    .a_i        (mac_a),
    .b_i        (mac_b),
    .acc_o      (acc)
  );

  // rounded sum to Q.16, saturated to 48 signed bits
  always_comb begin
    if ((&acc[ACC_W-1:63]) || !(|acc[ACC_W-1:63])) begin
      resid_c = acc[63:acss_pkg::FRAC_W];
    end else begin
      resid_c = acc[ACC_W-1] ? acss_pkg::RES_MIN : acss_pkg::RES_MAX;
    end
    css_sum_c = {18'b0, css_q} + {1'b0, acc[ACC_W-1:acss_pkg::FRAC_W]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ar_order_q   <= '0;
      ma_order_q   <= '0;
      diff_order_q <= '0;
      intercept_q  <= '0;
      for (int i = 0; i < AR_TAPS_MAX; i++) begin
        ar_coef_q[i]   <= '0;
        diff_hist_q[i] <= '0;
      end
      for (int i = 0; i < MA_TAPS_MAX; i++) begin
        ma_coef_q[i]  <= '0;
        res_hist_q[i] <= '0;
      end
      for (int i = 0; i <= DIFF_ORDER_MAX; i++) begin
        win_q[i] <= '0;
      end
      fill_q      <= '0;
      step_q      <= '0;
      css_q       <= '0;
      ovf_q       <= 1'b0;
      tap_q       <= '0;
      half_q      <= 1'b0;
      sq_step_q   <= '0;
      nma_q       <= '0;
      sq_en_q     <= 1'b0;
      diffv_q     <= '0;
      res_q       <= '0;
      rdy_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          acss_pkg::CFG_AR_ORDER:   ar_order_q   <= cfg_wdata_i[3:0];
          acss_pkg::CFG_MA_ORDER:   ma_order_q   <= cfg_wdata_i[3:0];
          acss_pkg::CFG_DIFF_ORDER: diff_order_q <= cfg_wdata_i[1:0];
          acss_pkg::CFG_INTERCEPT:  intercept_q  <= cfg_wdata_i;
          default: ;
        endcase
      end

      // in ST_OUT the output register is refilled below instead
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (in_data_i.operation)
              acss_pkg::OP_LOAD_AR: begin
                for (int i = 0; i < AR_TAPS_MAX; i++) begin
                  if (32'(in_data_i.coef_slot) == i) ar_coef_q[i] <= in_data_i.coef_value;
                end
              end
              acss_pkg::OP_LOAD_MA: begin
                for (int i = 0; i < MA_TAPS_MAX; i++) begin
                  if (32'(in_data_i.coef_slot) == i) ma_coef_q[i] <= in_data_i.coef_value;
                end
              end
              acss_pkg::OP_RESTART: begin
                for (int i = 0; i <= DIFF_ORDER_MAX; i++) begin
                  win_q[i] <= '0;
                end
                for (int i = 0; i < AR_TAPS_MAX; i++) begin
                  diff_hist_q[i] <= '0;
                end
                for (int i = 0; i < MA_TAPS_MAX; i++) begin
                  res_hist_q[i] <= '0;
                end
                fill_q <= '0;
                step_q <= '0;
                css_q  <= '0;
                ovf_q  <= 1'b0;
              end
              acss_pkg::OP_SAMPLE: begin
                for (int i = 0; i <= DIFF_ORDER_MAX; i++) begin
                  win_q[i] <= win_n[i];
                end
                fill_q  <= fill_n;
                diffv_q <= diffv_n;
                tap_q   <= '0;
                half_q  <= 1'b0;
                nma_q   <= nma_c;
                sq_en_q <= (step_q >= 32'(ncond_c)) && !ovf_q;
                rdy_q   <= ready_n;
                if (ready_n) begin
                  state_q <= ST_AR;
                end else begin
                  res_q   <= '0;
                  state_q <= ST_OUT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_AR: begin
          if (tap_q == p_c) begin
            tap_q   <= '0;
            half_q  <= 1'b0;
            state_q <= ST_MA;
          end else begin
            half_q <= !half_q;
            if (half_q) tap_q <= tap_q + TAP_W'(1);
          end
        end
        ST_MA: begin
          if (tap_q == nma_q) begin
            state_q <= ST_RES;
          end else begin
            half_q <= !half_q;
            if (half_q) tap_q <= tap_q + TAP_W'(1);
          end
        end
        ST_RES: begin
          res_q <= resid_c;
          if (p_c != '0) begin
            for (int i = AR_TAPS_MAX - 1; i > 0; i--) begin
              if (i < int'(p_c)) diff_hist_q[i] <= diff_hist_q[i-1];
            end
            diff_hist_q[0] <= diffv_q;
          end
          if (q_c != '0) begin
            for (int i = MA_TAPS_MAX - 1; i > 0; i--) begin
              if (i < int'(q_c)) res_hist_q[i] <= res_hist_q[i-1];
            end
            res_hist_q[0] <= resid_c;
          end
          if (step_q != {acss_pkg::STEP_W{1'b1}}) step_q <= step_q + 32'd1;
          sq_step_q <= '0;
          state_q   <= sq_en_q ? ST_SQ : ST_OUT;
        end
        ST_SQ: begin
          sq_step_q <= sq_step_q + 2'd1;
          if (sq_step_q == SQ_LAST) state_q <= ST_CSS;
        end
        ST_CSS: begin
          if (css_sum_c > {18'b0, acss_pkg::CSS_MAX}) begin
            css_q <= acss_pkg::CSS_MAX;
            ovf_q <= 1'b1;
          end else begin
            css_q <= css_sum_c[acss_pkg::CSS_W-1:0];
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          // hold the result until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_q.ready_res    <= rdy_q;
            out_q.residual     <= res_q;
            out_q.css_sum      <= css_q;
            out_q.css_overflow <= ovf_q;
            out_q.steps_done   <= step_q;
            out_valid_q        <= 1'b1;
            state_q            <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/acss_mac.sv]
// acss_mac: shared 33x25 signed multiplier with a 96-bit aligned accumulator.
// Depends on acss_pkg for widths, alignment codes and the control struct.

module acss_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  acss_pkg::mac_ctrl_t               ctrl_i,
  input  logic signed [acss_pkg::ACC_W-1:0]   load_val_i,
  input  logic signed [acss_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [acss_pkg::MUL_B_W-1:0] b_i,
  output logic signed [acss_pkg::ACC_W-1:0]   acc_o
);

  logic signed [acss_pkg::PROD_W-1:0] prod;
  logic signed [acss_pkg::ACC_W-1:0]  prod_ext;
  logic signed [acss_pkg::ACC_W-1:0]  term;
  logic signed [acss_pkg::ACC_W-1:0]  acc_q;
  logic signed [acss_pkg::ACC_W-1:0]  acc_d;

  always_comb begin
    prod     = a_i * b_i;
    prod_ext = acss_pkg::ACC_W'(prod);
    unique case (ctrl_i.shift)
      acss_pkg::SH_0:  term = prod_ext;
      acss_pkg::SH_24: term = prod_ext <<< 24;
      acss_pkg::SH_25: term = prod_ext <<< 25;
      acss_pkg::SH_48: term = prod_ext <<< 48;
      default:         term = prod_ext;
    endcase
    acc_d = acc_q;
    if (ctrl_i.load) begin
      acc_d = load_val_i;
    end else if (ctrl_i.mac) begin
      acc_d = ctrl_i.sub ? (acc_q - term) : (acc_q + term);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

[bench/css_check_pkg.sv]
// css_check_pkg: scoreboard for the ARIMA CSS residual accumulator bench. It keeps a
// bit-exact copy of the series state and queues the results each sample should give.
// Depends on acss_pkg for item types, operation codes and register indexes.

package css_check_pkg;
  import acss_pkg::*;

  localparam int AR_N      = AR_TAPS_MAX_DEF;
  localparam int MA_N      = MA_TAPS_MAX_DEF;
  localparam int D_N       = DIFF_ORDER_MAX_DEF;
  localparam int PRINT_CAP = 40;

  localparam longint           RES_TOP = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint           RES_BOT = -RES_TOP - 1;
  localparam logic [CSS_W-1:0] CSS_TOP = '1;

  class css_scoreboard;
    logic [3:0]       ar_ord, ma_ord;
    logic [1:0]       d_ord;
    longint           icpt;
    longint           ar_coef [AR_N];
    longint           ma_coef [MA_N];
    longint           raw_win [D_N+1];
    int               win_fill;
    longint           diff_hist [AR_N];
    longint           res_hist [MA_N];
    int unsigned      step_cnt;
    logic [CSS_W-1:0] css_acc;
    bit               css_ovf;
    out_item_t        pending_results [$];
    int               errors;
    int               n_results;

    function new();
      ar_ord = '0;
      ma_ord = '0;
      d_ord  = '0;
      icpt   = 0;
      foreach (ar_coef[i]) ar_coef[i] = 0;
      foreach (ma_coef[i]) ma_coef[i] = 0;
      errors    = 0;
      n_results = 0;
      clear_series();
    endfunction

    function void clear_series();
      foreach (raw_win[i]) raw_win[i] = 0;
      foreach (diff_hist[i]) diff_hist[i] = 0;
      foreach (res_hist[i]) res_hist[i] = 0;
      win_fill = 0;
      step_cnt = 0;
      css_acc  = '0;
      css_ovf  = 1'b0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_AR_ORDER:   ar_ord = val[3:0];
        CFG_MA_ORDER:   ma_ord = val[3:0];
        CFG_DIFF_ORDER: d_ord  = val[1:0];
        CFG_INTERCEPT:  icpt   = $signed(val);
        default: ;
      endcase
    endfunction

    // Called once per accepted input transaction; samples queue one expected result.
    function void note_item(in_item_t it);
      int                  p, q, d, ncond, nma, i, j;
      int unsigned         span;
      longint              y, diffv, resid, rmag;
      longint              work [D_N+1];
      logic signed [127:0] acc;
      logic [127:0]        sq, tot;
      bit                  ready;
      out_item_t           res;

      case (it.operation)
        OP_LOAD_AR: if (it.coef_slot < AR_N) ar_coef[it.coef_slot] = $signed(it.coef_value);
        OP_LOAD_MA: if (it.coef_slot < MA_N) ma_coef[it.coef_slot] = $signed(it.coef_value);
        OP_RESTART: clear_series();
        default: ;
      endcase
      if (it.operation != OP_SAMPLE) return;

      p     = (ar_ord > AR_N) ? AR_N : int'(ar_ord);
      q     = (ma_ord > MA_N) ? MA_N : int'(ma_ord);
      d     = (d_ord > D_N) ? D_N : int'(d_ord);
      ncond = (p > q) ? p : q;
      y     = $signed(it.sample);
      resid = 0;
      diffv = y;
      ready = 1'b1;

      if (d > 0) begin
        if (win_fill < d + 1) begin
          raw_win[win_fill] = y;
          win_fill++;
          ready = (win_fill >= d + 1);
        end else begin
          // also covers a window left over-full after d was lowered: it just slides
          for (i = 0; i < d; i++) raw_win[i] = raw_win[i+1];
          raw_win[d] = y;
        end
        for (i = 0; i <= d; i++) work[i] = raw_win[i];
        for (i = 0; i < d; i++)
          for (j = 0; j < d - i; j++) work[j] = work[j+1] - work[j];
        diffv = work[0];
      end

      if (ready) begin
        // exact Q.32 accumulation, one rounding step at the end
        acc = diffv - icpt;
        acc = acc <<< FRAC_W;
        for (i = 0; i < p; i++) acc = acc - ar_coef[i] * diff_hist[i];
        nma = 0;
        if (step_cnt > ncond) begin
          span = step_cnt - ncond;
          nma  = (span < q) ? int'(span) : q;
        end
        for (i = 0; i < nma; i++) acc = acc - ma_coef[i] * res_hist[i];
        acc = (acc + 32768) >>> FRAC_W;
        if (acc > RES_TOP) resid = RES_TOP;
        else if (acc < RES_BOT) resid = RES_BOT;
        else resid = longint'(acc);

        if (step_cnt >= ncond && !css_ovf) begin
          rmag = (resid < 0) ? -resid : resid;
          sq   = rmag;
          sq   = (sq * sq + 32768) >> FRAC_W;
          tot  = sq + css_acc;
          if (tot > CSS_TOP) begin
            css_acc = CSS_TOP;
            css_ovf = 1'b1;
          end else begin
            css_acc = tot[CSS_W-1:0];
          end
        end
        if (step_cnt != 32'hFFFF_FFFF) step_cnt++;

        if (p > 0) begin
          for (i = p - 1; i > 0; i--) diff_hist[i] = diff_hist[i-1];
          diff_hist[0] = diffv;
        end
        if (q > 0) begin
          for (i = q - 1; i > 0; i--) res_hist[i] = res_hist[i-1];
          res_hist[0] = resid;
        end
      end

      res.ready_res    = ready;
      res.residual     = resid[RES_W-1:0];
      res.css_sum      = css_acc;
      res.css_overflow = css_ovf;
      res.steps_done   = step_cnt;
      pending_results.push_back(res);
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      n_results++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", n_results));
        return;
      end
      want = pending_results.pop_front();
      check_field("ready_res", got.ready_res, want.ready_res);
      check_field("residual", got.residual, want.residual);
      check_field("css_sum", got.css_sum, want.css_sum);
      check_field("css_overflow", got.css_overflow, want.css_overflow);
      check_field("steps_done", got.steps_done, want.steps_done);
    endtask

    task check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("result %0d: %s is %0h, expected %0h", n_results, name, got, want));
    endtask

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("[%0t] MISMATCH %s", $time, msg);
    endtask
  endclass

endpackage

[bench/tb.sv]
// tb: top-level bench for arima_css_residual_accumulator_top. Directed edge cases, then
// random series with random valid/ready gaps. Depends on acss_pkg and css_check_pkg.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import acss_pkg::*;
  import css_check_pkg::*;

  localparam int TOTAL_ITEMS   = 1550;
  localparam int IDLE_PCT      = 27;
  localparam int SETTLE_CYCLES = 50;
  localparam int LIMIT_CYCLES  = 1000000;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [1:0] cfg_idx  = '0;
  logic [31:0] cfg_wdata = '0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  css_scoreboard sb = new();
  int items_sent   = 0;
  int results_seen = 0;

  arima_css_residual_accumulator_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_item_t make_item(logic [1:0] op, logic [2:0] slot,
                                         logic [31:0] coef, logic [31:0] samp);
    in_item_t it;
    it.operation  = op;
    it.coef_slot  = slot;
    it.coef_value = coef;
    it.sample     = samp;
    return it;
  endfunction

  // mostly a sign-extended nb-bit value, sometimes the full 32-bit range
  function automatic logic [31:0] rnd_word(int wide_pct, int nb);
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(99) >= wide_pct) w = $signed(w) >>> (32 - nb);
    return w;
  endfunction

  // legal order most of the time; upper bits are don't-care and left random
  function automatic logic [31:0] rnd_order(int top);
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(9) == 0) w[3:0] = 4'($urandom_range(15, top + 1));
    else w[3:0] = 4'($urandom_range(top));
    return w;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic program_regs(input logic [31:0] ar, input logic [31:0] ma,
                              input logic [31:0] dd, input logic [31:0] ic);
    write_reg(CFG_AR_ORDER, ar);
    write_reg(CFG_MA_ORDER, ma);
    write_reg(CFG_DIFF_ORDER, dd);
    write_reg(CFG_INTERCEPT, ic);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input in_item_t it);
    while (!(items_sent >= 700 && items_sent < 950) && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  // drain: all results back, then let trailing loads/restarts retire
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] swing [6];
    int n_loads, n_samp;
    swing = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme coefficients, warm-up, full-scale swings, restart
    program_regs(32'd2, 32'd2, 32'd1, 32'h0001_0000);
    send_item(make_item(OP_LOAD_AR, 3'd0, 32'h7FFF_FFFF, 32'h0000_0000));
    send_item(make_item(OP_LOAD_AR, 3'd7, 32'h8000_0000, 32'hFFFF_FFFF));
    send_item(make_item(OP_LOAD_AR, 3'd1, 32'h0000_8000, 32'h0000_0000));
    send_item(make_item(OP_LOAD_MA, 3'd0, 32'hFFFF_0000, 32'h0000_0000));
    send_item(make_item(OP_LOAD_MA, 3'd7, 32'h7FFF_FFFF, 32'h0000_0000));
    send_item(make_item(OP_LOAD_MA, 3'd1, 32'h0000_4000, 32'h0000_0000));
    foreach (swing[k]) send_item(make_item(OP_SAMPLE, 3'd0, 32'h0, swing[k]));
    send_item(make_item(OP_RESTART, 3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(make_item(OP_SAMPLE, 3'd0, 32'h0, 32'h0001_0000));
    send_item(make_item(OP_SAMPLE, 3'd0, 32'h0, 32'h0002_0000));
    send_item(make_item(OP_SAMPLE, 3'd0, 32'h0, 32'hFFFF_0000));

    // orders above maximum, d raised mid-series
    settle();
    program_regs(32'hFFFF_FFFF, 32'h0000_000F, 32'h0000_0003, 32'h8000_0000);
    foreach (swing[k]) send_item(make_item(OP_SAMPLE, 3'd0, 32'h0, swing[k]));

    // no differencing, no taps, largest intercept
    settle();
    program_regs(32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
    send_item(make_item(OP_SAMPLE, 3'd0, 32'h0, 32'h7FFF_FFFF));
    send_item(make_item(OP_SAMPLE, 3'd0, 32'h0, 32'h8000_0000));

    // window holds three entries while d drops to one
    settle();
    program_regs(32'd1, 32'd1, 32'd1, 32'h0000_0000);
    send_item(make_item(OP_SAMPLE, 3'd0, 32'h0, 32'h0000_0001));

    // random series: new settings, usually a restart, some loads, then mostly samples
    while (items_sent < TOTAL_ITEMS) begin
      settle();
      program_regs(rnd_order(AR_N), rnd_order(MA_N), rnd_order(D_N), rnd_word(20, 20));
      if ($urandom_range(99) < 70)
        send_item(make_item(OP_RESTART, 3'($urandom), $urandom, $urandom));
      n_loads = $urandom_range(16);
      repeat (n_loads)
        send_item(make_item($urandom_range(1) ? OP_LOAD_MA : OP_LOAD_AR, 3'($urandom),
                            rnd_word(15, 14), $urandom));
      n_samp = $urandom_range(70, 20);
      repeat (n_samp) begin
        if ($urandom_range(99) < 6)
          send_item(make_item(2'($urandom), 3'($urandom), $urandom, $urandom));
        else
          send_item(make_item(OP_SAMPLE, 3'($urandom), $urandom, rnd_word(12, 21)));
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("** arima_css_residual_accumulator_top: PASSED **");
    end else begin
      $display("** arima_css_residual_accumulator_top: FAILED **");
    end
    $finish;
  end

  initial begin : result_sink
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
        results_seen++;
      end
      // one long back-pressure window while the sender keeps offering
      if (!held && results_seen >= 200 && in_valid) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_seen >= 600 && results_seen < 850) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("** arima_css_residual_accumulator_top: FAILED **");
    $finish;
  end

endmodule
